[rtl/drp_pkg.sv]
`default_nettype none

package drp_pkg;

  // parse phase of the back end
  typedef enum logic [3:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QPTR,
    PH_QFIXED,
    PH_ANAME,
    PH_APTR,
    PH_AFIXED,
    PH_RDATA,
    PH_ADDR,
    PH_DONE
  } phase_t;

  // result codes
  localparam logic [2:0] ST_FOUND = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_BADID = 3'd2;
  localparam logic [2:0] ST_BADQ  = 3'd3;
  localparam logic [2:0] ST_NOANS = 3'd4;
  localparam logic [2:0] ST_NOV4  = 3'd5;
  localparam logic [2:0] ST_TRUNC = 3'd6;

  // header byte positions
  localparam logic [3:0] HDR_ID_END = 4'd1;
  localparam logic [3:0] HDR_QD_END = 4'd5;
  localparam logic [3:0] HDR_AN_END = 4'd7;
  localparam logic [3:0] HDR_END    = 4'd11;
  localparam logic [3:0] HDR_IDX_SAT = 4'd15;
  localparam int unsigned HDR_BYTES = 12;

  // name and record constants
  localparam logic [7:0]  PTR_MARK     = 8'hC0;
  localparam logic [3:0]  QFIXED_LEN   = 4'd4;
  localparam logic [3:0]  AF_TYPE_END  = 4'd1;
  localparam logic [3:0]  AF_LEN_END   = 4'd9;
  localparam logic [3:0]  ADDR_LEN     = 4'd4;
  localparam logic [15:0] TYPE_A       = 16'd1;
  localparam logic [15:0] A_DATA_LEN   = 16'd4;
  localparam logic [15:0] ONE_QUESTION = 16'd1;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       parse;
    logic [3:0] hidx;
    logic       short_pkt;
  } item_t;

endpackage

`default_nettype wire

[rtl/dns_response_address_parser.sv]
`default_nettype none

// Parses one DNS response fed as payload bytes, one byte per beat with tlast on the final
// byte, and gives one result beat per packet: a status code and the address of the first
// type-1 answer record. The header id is checked against the expected_id register (write
// cfg_we/cfg_wdata only between packets). A byte is taken every cycle while the queue has
// room; the front end tags each byte with its packet position, a two-entry queue decouples
// it from the back end, which advances the parse state by one byte per cycle. The result
// is registered when the back end takes the last byte from the queue, and the back end
// stalls only when a new result finds the output register still full. Bytes at
// MAX_PACKET_BYTES and beyond are not parsed but their tlast still closes the packet.
module dns_response_address_parser
  import drp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] payload_byte
  input  wire logic        s_tlast,   // is_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [2:0] status, [34:3] address, [39:35] zero
);

  item_t       front_item;
  item_t       head_item;
  logic        q_not_full;
  logic        q_not_empty;
  logic        q_pop;
  logic [2:0]  res_status;
  logic [31:0] res_address;

  assign s_tready = q_not_full;
  assign m_tdata  = {5'd0, res_address, res_status};

  // byte classification
  drp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (q_not_full),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .item     (front_item)
  );

  // queue between front and back
  drp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_item (front_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  // parser and result register
  drp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_valid  (q_not_empty),
    .item        (head_item),
    .item_pop    (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (res_status),
    .out_address (res_address)
  );

endmodule

`default_nettype wire

[rtl/drp_front.sv]
`default_nettype none

module drp_front
  import drp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_ready,
  input  wire logic  [7:0] in_data,
  input  wire logic  in_last,
  output item_t      item
);

  localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_PACKET_BYTES);
  localparam logic [CW-1:0] SHORT_CNT = CW'(HDR_BYTES);
  localparam logic [CW-1:0] SAT_CNT   = CW'(HDR_IDX_SAT);

  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;
  logic          beat;
  logic          parse;

  assign beat  = in_valid && in_ready;
  assign parse = byte_count < MAX_CNT;

  // tag the byte with its position class
  always_comb begin
    item.data      = in_data;
    item.last      = in_last;
    item.parse     = parse;
    item.hidx      = (byte_count < SAT_CNT) ? byte_count[3:0] : HDR_IDX_SAT;
    item.short_pkt = byte_count < SHORT_CNT;
  end

  // byte position within the packet, saturating at the parse limit
  always_comb begin
    byte_count_next = byte_count;
    if (beat) begin
      if (in_last) begin
        byte_count_next = '0;
      end else if (parse) begin
        byte_count_next = byte_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

[rtl/drp_fifo.sv]
`default_nettype none

module drp_fifo
  import drp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      push_item,
  output logic       not_full,
  input  wire logic  pop,
  output logic       not_empty,
  output item_t      head
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign not_full  = fill != 2'd2;
  assign not_empty = fill != 2'd0;
  assign head      = slot[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && not_full) begin
      slot[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && not_full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push && not_full) - 2'(pop && not_empty);
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
      (fill == 2'd0) |-> !not_empty)
    else $error("queue reports data while empty");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
      (fill == 2'd2 && !pop) |=> fill == 2'd2)
    else $error("queue lost an entry while full");

endmodule

`default_nettype wire

[rtl/drp_back.sv]
`default_nettype none

module drp_back
  import drp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  [15:0] cfg_wdata,
  input  wire logic  item_valid,
  input  item_t      item,
  output logic       item_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [2:0] out_status,
  output logic [31:0] out_address
);

  logic [15:0] expected_id;

  phase_t      phase, phase_next;
  logic [3:0]  field_offset, field_offset_next;
  logic [15:0] field_shift, field_shift_next;
  logic [5:0]  label_left, label_left_next;
  logic [15:0] answers_total, answers_total_next;
  logic [15:0] answers_seen, answers_seen_next;
  logic [15:0] record_type, record_type_next;
  logic [31:0] address_accum, address_accum_next;
  logic [2:0]  outcome, outcome_next;

  logic [15:0] shift_in;
  logic [15:0] shift_dec;
  logic [15:0] seen_inc;
  logic [3:0]  offset_inc;
  logic        name_q;
  logic [2:0]  status_next;
  logic        finish_pkt;

  assign shift_in   = {field_shift[7:0], item.data};
  assign shift_dec  = field_shift - 16'd1;
  assign seen_inc   = answers_seen + 16'd1;
  assign offset_inc = field_offset + 4'd1;
  assign name_q     = phase == PH_QNAME;

  // a last byte needs the result register free, others go straight through
  assign item_pop   = item_valid && (!item.last || !out_valid || out_ready);
  assign finish_pkt = item_pop && item.last;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
    end else if (cfg_we) begin
      expected_id <= cfg_wdata;
    end
  end

  // parse step for one byte
  always_comb begin
    phase_next         = phase;
    field_offset_next  = field_offset;
    field_shift_next   = field_shift;
    label_left_next    = label_left;
    answers_total_next = answers_total;
    answers_seen_next  = answers_seen;
    record_type_next   = record_type;
    address_accum_next = address_accum;
    outcome_next       = outcome;
    if (item.parse) begin
      unique case (phase)
        PH_HEADER: begin
          field_shift_next = shift_in;
          priority if (item.hidx == HDR_ID_END && shift_in != expected_id) begin
            outcome_next = ST_BADID;
            phase_next   = PH_DONE;
          end else if (item.hidx == HDR_QD_END && shift_in != ONE_QUESTION) begin
            outcome_next = ST_BADQ;
            phase_next   = PH_DONE;
          end else if (item.hidx == HDR_AN_END) begin
            answers_total_next = shift_in;
            if (shift_in == 16'd0) begin
              outcome_next = ST_NOANS;
              phase_next   = PH_DONE;
            end
          end else if (item.hidx == HDR_END) begin
            phase_next      = PH_QNAME;
            label_left_next = '0;
          end else begin
            phase_next = phase;
          end
        end
        PH_QNAME, PH_ANAME: begin
          priority if (label_left != 6'd0) begin
            label_left_next = label_left - 6'd1;
          end else if (item.data == 8'd0) begin
            phase_next        = name_q ? PH_QFIXED : PH_AFIXED;
            field_offset_next = '0;
            field_shift_next  = '0;
          end else if ((item.data & PTR_MARK) == PTR_MARK) begin
            phase_next = name_q ? PH_QPTR : PH_APTR;
          end else begin
            label_left_next = item.data[5:0];
          end
        end
        PH_QPTR, PH_APTR: begin
          phase_next        = (phase == PH_QPTR) ? PH_QFIXED : PH_AFIXED;
          field_offset_next = '0;
          field_shift_next  = '0;
        end
        PH_QFIXED: begin
          field_offset_next = offset_inc;
          if (offset_inc >= QFIXED_LEN) begin
            phase_next        = PH_ANAME;
            answers_seen_next = '0;
            label_left_next   = '0;
          end
        end
        PH_AFIXED: begin
          field_shift_next = shift_in;
          if (field_offset == AF_TYPE_END) begin
            record_type_next = shift_in;
          end
          if (field_offset == AF_LEN_END) begin
            field_offset_next = '0;
            priority if (record_type == TYPE_A) begin
              if (shift_in == A_DATA_LEN) begin
                phase_next         = PH_ADDR;
                address_accum_next = '0;
              end else begin
                outcome_next = ST_NOV4;
                phase_next   = PH_DONE;
              end
            end else if (shift_in == 16'd0) begin
              answers_seen_next = seen_inc;
              if (seen_inc >= answers_total) begin
                outcome_next = ST_NOV4;
                phase_next   = PH_DONE;
              end else begin
                phase_next      = PH_ANAME;
                label_left_next = '0;
              end
            end else begin
              phase_next = PH_RDATA;
            end
          end else begin
            field_offset_next = offset_inc;
          end
        end
        PH_RDATA: begin
          field_shift_next = shift_dec;
          if (shift_dec == 16'd0) begin
            answers_seen_next = seen_inc;
            if (seen_inc >= answers_total) begin
              outcome_next = ST_NOV4;
              phase_next   = PH_DONE;
            end else begin
              phase_next      = PH_ANAME;
              label_left_next = '0;
            end
          end
        end
        PH_ADDR: begin
          unique case (field_offset[1:0])
            2'd0: address_accum_next[7:0]   = address_accum[7:0]   | item.data;
            2'd1: address_accum_next[15:8]  = address_accum[15:8]  | item.data;
            2'd2: address_accum_next[23:16] = address_accum[23:16] | item.data;
            2'd3: address_accum_next[31:24] = address_accum[31:24] | item.data;
            default: address_accum_next = address_accum;
          endcase
          field_offset_next = offset_inc;
          if (offset_inc >= ADDR_LEN) begin
            outcome_next = ST_FOUND;
            phase_next   = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // result of the packet on its last byte
  always_comb begin
    status_next = item.short_pkt ? ST_SHORT : outcome_next;
  end

  // parse state, cleared after every result
  always_ff @(posedge clk) begin
    if (rst || finish_pkt) begin
      phase         <= PH_HEADER;
      field_offset  <= '0;
      field_shift   <= '0;
      label_left    <= '0;
      answers_total <= '0;
      answers_seen  <= '0;
      record_type   <= '0;
      address_accum <= '0;
      outcome       <= ST_TRUNC;
    end else if (item_pop) begin
      phase         <= phase_next;
      field_offset  <= field_offset_next;
      field_shift   <= field_shift_next;
      label_left    <= label_left_next;
      answers_total <= answers_total_next;
      answers_seen  <= answers_seen_next;
      record_type   <= record_type_next;
      address_accum <= address_accum_next;
      outcome       <= outcome_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_pkt) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_pkt) begin
      out_status  <= status_next;
      out_address <= (status_next == ST_FOUND) ? address_accum_next : 32'd0;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
      finish_pkt |=> (phase == PH_HEADER && outcome == ST_TRUNC))
    else $error("parse state not cleared after a result");
  a_addr_only_found: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_status != ST_FOUND) |-> out_address == 32'd0)
    else $error("address given without a found status");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |-> !finish_pkt)
    else $error("result overwritten while stalled");
  a_label_in_name: assert property (@(posedge clk) disable iff (rst)
      (label_left != 6'd0) |-> (phase == PH_QNAME || phase == PH_ANAME))
    else $error("label count live outside a name");

endmodule

`default_nettype wire
